// File: rtl/single_cycle_mips_core_step_top_macros.svh
// ----------------------------------------------------------------------------
// single_cycle_mips_core_step_top_macros.svh
// Assertion shorthands for the core step block. Expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SINGLE_CYCLE_MIPS_CORE_STEP_TOP_MACROS_SVH
`define SINGLE_CYCLE_MIPS_CORE_STEP_TOP_MACROS_SVH

// same-cycle implication
`define SCM_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scm check failed");

// next-cycle implication
`define SCM_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scm check failed");

`endif

// File: rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared constants, opcodes and types of the MIPS subset core step block.
// ----------------------------------------------------------------------------
package scm_pkg;

	localparam int IMEM_AW    = 10;
	localparam int IMEM_WORDS = 1 << IMEM_AW;
	localparam int DMEM_AW    = 10;
	localparam int DMEM_WORDS = 1 << DMEM_AW;
	localparam int REG_AW     = 5;
	localparam int REG_COUNT  = 1 << REG_AW;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 168;

	// action codes
	localparam logic [1:0] ACT_RUN     = 2'd0;
	localparam logic [1:0] ACT_LD_IMEM = 2'd1;
	localparam logic [1:0] ACT_LD_DMEM = 2'd2;

	// opcodes
	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2B;

	// R-type function codes
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2A;

	typedef struct packed {
		logic              reg_wr;
		logic [REG_AW-1:0] reg_idx;
		logic [31:0]       reg_val;
		logic              is_lw;
		logic              mem_wr;
		logic [31:0]       mem_addr;
		logic [31:0]       mem_val;
		logic [31:0]       ea;
		logic              taken;
		logic [31:0]       next_pc;
	} exec_t;

endpackage

// File: rtl/scm_regfile.sv
// ----------------------------------------------------------------------------
// scm_regfile
// Register file: two synchronous read ports, one write port, per-entry valid
// bits so unwritten registers and register zero read as zero.
// ----------------------------------------------------------------------------
module scm_regfile (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [scm_pkg::REG_AW-1:0] rd_addr_a,
	input  logic [scm_pkg::REG_AW-1:0] rd_addr_b,
	output logic [31:0]               rd_data_a,
	output logic [31:0]               rd_data_b,
	input  logic                      wr_en,
	input  logic [scm_pkg::REG_AW-1:0] wr_addr,
	input  logic [31:0]               wr_data
);

	logic [31:0]                   rf_q [scm_pkg::REG_COUNT];
	logic [scm_pkg::REG_COUNT-1:0] valid_q;
	logic [31:0]                   rdata_a_q;
	logic [31:0]                   rdata_b_q;
	logic                          live_a_q;
	logic                          live_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_a_q <= rf_q[rd_addr_a];
			rdata_b_q <= rf_q[rd_addr_b];
			live_a_q  <= valid_q[rd_addr_a] && (rd_addr_a != '0);
			live_b_q  <= valid_q[rd_addr_b] && (rd_addr_b != '0);
		end
	end

	assign rd_data_a = live_a_q ? rdata_a_q : '0;
	assign rd_data_b = live_b_q ? rdata_b_q : '0;

endmodule

// File: rtl/scm_exec.sv
// ----------------------------------------------------------------------------
// scm_exec
// Decode and execute of one instruction: ALU, effective address, branch and
// jump target, write-back selection.
// ----------------------------------------------------------------------------
module scm_exec (
	input  logic                  run,
	input  logic [31:0]           pc,
	input  logic [31:0]           instr,
	input  logic [31:0]           rs_val,
	input  logic [31:0]           rt_val,
	output scm_pkg::exec_t        result
);

	logic [5:0]  opc;
	logic [5:0]  funct;
	logic [31:0] imm_ext;
	logic [31:0] pc4;
	logic [31:0] alu;

	assign opc     = instr[31:26];
	assign funct   = instr[5:0];
	assign imm_ext = {{16{instr[15]}}, instr[15:0]};
	assign pc4     = pc + 32'd4;

	always_comb begin
		unique case (funct)
			scm_pkg::FN_ADD: alu = rs_val + rt_val;
			scm_pkg::FN_SUB: alu = rs_val - rt_val;
			scm_pkg::FN_AND: alu = rs_val & rt_val;
			scm_pkg::FN_OR:  alu = rs_val | rt_val;
			scm_pkg::FN_SLT: alu = {31'd0, rs_val < rt_val};
			default:         alu = '0;
		endcase
	end

	always_comb begin
		result         = '0;
		result.ea      = rs_val + imm_ext;
		result.next_pc = run ? pc4 : pc;
		if (run) begin
			unique case (opc)
				scm_pkg::OPC_LW: begin
					result.reg_wr  = 1'b1;
					result.reg_idx = instr[20:16];
					result.is_lw   = 1'b1;
				end
				scm_pkg::OPC_SW: begin
					result.mem_wr   = 1'b1;
					result.mem_addr = rs_val + imm_ext;
					result.mem_val  = rt_val;
				end
				scm_pkg::OPC_RTYPE: begin
					result.reg_wr  = 1'b1;
					result.reg_idx = instr[15:11];
					result.reg_val = alu;
				end
				scm_pkg::OPC_BEQ: begin
					if (rs_val == rt_val) begin
						result.next_pc = pc4 + {imm_ext[29:0], 2'b00};
						result.taken   = 1'b1;
					end
				end
				scm_pkg::OPC_J: begin
					result.next_pc = {pc4[31:28], instr[25:0], 2'b00};
					result.taken   = 1'b1;
				end
				default: begin
				end
			endcase
		end
		// writes to register zero are dropped
		if (result.reg_wr && result.reg_idx == '0) begin
			result.reg_wr  = 1'b0;
			result.reg_val = '0;
		end
	end

endmodule

// File: rtl/single_cycle_mips_core_step_top.sv
// ----------------------------------------------------------------------------
// single_cycle_mips_core_step_top
// Each input word loads one word into instruction or data memory, runs one
// step of a MIPS subset core (lw, sw, beq, j, add, sub, and, or, unsigned
// slt) or, for an unused action code, changes nothing; each word returns one
// result word with the new PC, the executed instruction, the register
// write-back, the store and the redirect flag. Load words are taken one per
// clock while no stage stalls and no run word is ahead of execute. A run word
// passes fetch (imem read), register read and execute/data memory access, and
// the next word is taken once it has left execute, where the PC is updated.
// Results pass stages s1, s2, s3 and the output register, which lets the
// pipeline keep filling while a result waits for m_tready.
// ----------------------------------------------------------------------------
`include "single_cycle_mips_core_step_top_macros.svh"

module single_cycle_mips_core_step_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// load_address[11:0], load_value[43:12], zero fill [47:44]
	input  logic [scm_pkg::S_TDATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// new_pc[31:0], executed_instruction[63:32], reg_written[64],
	// reg_index[69:65], reg_value[101:70], mem_written[102],
	// mem_address[134:103], mem_value[166:135], flow_taken[167]
	output logic [scm_pkg::M_TDATA_W-1:0]  m_tdata
);

	logic [31:0] imem_q [scm_pkg::IMEM_WORDS];
	logic [31:0] dmem_q [scm_pkg::DMEM_WORDS];
	logic [31:0] imem_rdata_q;
	logic [31:0] dmem_rdata_q;
	logic [31:0] pc_q;

	logic        valid_s1, run_s1;
	logic [31:0] pc_s1;
	logic        valid_s2, run_s2;
	logic [31:0] pc_s2, instr_s2;
	logic        valid_s3;
	logic [31:0] instr_s3;
	scm_pkg::exec_t x_s2, x_s3;

	logic                          out_valid_q;
	logic [scm_pkg::M_TDATA_W-1:0] out_data_q;

	logic        accept, out_free;
	logic        mv1, mv2, mv3, free1, free2, free3;
	logic [11:0] load_address;
	logic [31:0] load_value, load_ext;
	logic        act_run, act_ld_imem, act_ld_dmem;
	logic [31:0] rf_a, rf_b, reg_value_s3;

	logic                       dmem_we, dmem_re;
	logic [scm_pkg::DMEM_AW-1:0] dmem_waddr;
	logic [31:0]                dmem_wdata;

	assign load_address = s_tdata[11:0];
	assign load_value   = s_tdata[43:12];
	assign load_ext     = 32'(load_address);
	assign act_run      = s_tuser == scm_pkg::ACT_RUN;
	assign act_ld_imem  = s_tuser == scm_pkg::ACT_LD_IMEM;
	assign act_ld_dmem  = s_tuser == scm_pkg::ACT_LD_DMEM;

	// stage flow: a stage moves when the next one is empty or moving
	assign out_free = !out_valid_q || m_tready;
	assign mv3      = valid_s3 && out_free;
	assign free3    = !valid_s3 || out_free;
	assign mv2      = valid_s2 && free3;
	assign free2    = !valid_s2 || free3;
	assign mv1      = valid_s1 && free2;
	assign free1    = !valid_s1 || free2;

	// PC interlock: hold input while a run word has not yet resolved the PC
	assign s_tready = free1 && !(valid_s1 && run_s1) && !(valid_s2 && run_s2);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (mv1) begin
				valid_s1 <= 1'b0;
			end
			if (mv1) begin
				valid_s2 <= 1'b1;
			end else if (mv2) begin
				valid_s2 <= 1'b0;
			end
			if (mv2) begin
				valid_s3 <= 1'b1;
			end else if (mv3) begin
				valid_s3 <= 1'b0;
			end
			if (mv3) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mv2 && run_s2) begin
				pc_q <= x_s2.next_pc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1 <= act_run;
			pc_s1  <= pc_q;
		end
		if (mv1) begin
			run_s2   <= run_s1;
			pc_s2    <= pc_s1;
			instr_s2 <= run_s1 ? imem_rdata_q : '0;
		end
		if (mv2) begin
			x_s3     <= x_s2;
			instr_s3 <= instr_s2;
		end
		if (mv3) begin
			out_data_q <= {x_s3.taken, x_s3.mem_val, x_s3.mem_addr, x_s3.mem_wr,
				reg_value_s3, x_s3.reg_idx, x_s3.reg_wr, instr_s3, x_s3.next_pc};
		end
	end

	// instruction memory: loads write, run words fetch at the current PC
	always_ff @(posedge clk) begin
		if (accept && act_ld_imem) begin
			imem_q[load_ext[scm_pkg::IMEM_AW+1:2]] <= load_value;
		end
		if (accept && act_run) begin
			imem_rdata_q <= imem_q[pc_q[scm_pkg::IMEM_AW+1:2]];
		end
	end

	scm_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (mv1),
		.rd_addr_a (imem_rdata_q[25:21]),
		.rd_addr_b (imem_rdata_q[20:16]),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b),
		.wr_en     (valid_s3 && x_s3.reg_wr),
		.wr_addr   (x_s3.reg_idx),
		.wr_data   (reg_value_s3)
	);

	scm_exec u_exec (
		.run    (run_s2),
		.pc     (pc_s2),
		.instr  (instr_s2),
		.rs_val (rf_a),
		.rt_val (rf_b),
		.result (x_s2)
	);

	// data memory: load words write at acceptance, sw writes and lw reads
	// as the run word leaves execute; the interlock keeps these apart
	assign dmem_we    = (accept && act_ld_dmem) || (mv2 && x_s2.mem_wr);
	assign dmem_re    = mv2 && x_s2.is_lw;
	assign dmem_waddr = (accept && act_ld_dmem) ? load_ext[scm_pkg::DMEM_AW+1:2]
		: x_s2.mem_addr[scm_pkg::DMEM_AW+1:2];
	assign dmem_wdata = (accept && act_ld_dmem) ? load_value : x_s2.mem_val;

	always_ff @(posedge clk) begin
		if (dmem_we) begin
			dmem_q[dmem_waddr] <= dmem_wdata;
		end
		if (dmem_re) begin
			dmem_rdata_q <= dmem_q[x_s2.ea[scm_pkg::DMEM_AW+1:2]];
		end
	end

	assign reg_value_s3 = (x_s3.is_lw && x_s3.reg_wr) ? dmem_rdata_q : x_s3.reg_val;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// the PC only moves when a run word leaves execute
	`SCM_ASSERT_NXT(a_pc_hold_fetch, valid_s1 && run_s1, pc_q == $past(pc_q))
	// never two run words ahead of execute at once
	`SCM_ASSERT_IMP(a_one_run_front, valid_s1 && run_s1, !(valid_s2 && run_s2))
	// a word that came in behind a run word sees the resolved PC
	`SCM_ASSERT_NXT(a_run_pc_commit, mv2 && run_s2, pc_q == x_s3.next_pc)

endmodule

// File: tb/scm_step_monitor.sv
// ----------------------------------------------------------------------------
// scm_step_monitor
// Watches both stream channels of the MIPS subset core step block, predicts
// every result word from its own copy of PC, register file and memories, and
// compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module scm_step_monitor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	// load_address[11:0], load_value[43:12], zero fill [47:44]
	input  logic [scm_pkg::S_TDATA_W-1:0]         s_tdata,
	// action[1:0]
	input  logic [1:0]                            s_tuser,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	// new_pc[31:0], executed_instruction[63:32], reg_written[64],
	// reg_index[69:65], reg_value[101:70], mem_written[102],
	// mem_address[134:103], mem_value[166:135], flow_taken[167]
	input  logic [scm_pkg::M_TDATA_W-1:0]         m_tdata,
	output int                                    errors,
	output int                                    pending,
	output int                                    words_checked,
	output logic [31:0]                           pc_state,
	output logic [scm_pkg::REG_COUNT-1:0][31:0]   gpr_state
);
	timeunit 1ns;
	timeprecision 1ps;

	import scm_pkg::*;

	// lowest field last, so a cast from m_tdata lines up
	typedef struct packed {
		logic              taken;
		logic [31:0]       mem_val;
		logic [31:0]       mem_addr;
		logic              mem_wr;
		logic [31:0]       reg_val;
		logic [REG_AW-1:0] reg_idx;
		logic              reg_wr;
		logic [31:0]       instr;
		logic [31:0]       new_pc;
	} step_result_t;

	logic [31:0]                 core_pc = '0;
	logic [REG_COUNT-1:0][31:0]  core_gpr = '0;
	logic [31:0]                 core_imem [IMEM_WORDS];
	logic [31:0]                 core_dmem [DMEM_WORDS];
	step_result_t                retire_q [$];
	step_result_t                got, want;

	initial begin
		errors = 0;
		pending = 0;
		words_checked = 0;
	end

	assign pc_state  = core_pc;
	assign gpr_state = core_gpr;

	task automatic report(input string what, input logic [31:0] seen, input logic [31:0] exp);
		if (errors < 40)
			$display("%0t ns mismatch: %s got %h expected %h", $realtime, what, seen, exp);
		errors++;
	endtask

	// Applies one input word to the shadow core and returns the word it must produce.
	function automatic step_result_t retire_item(input logic [1:0] act,
		input logic [11:0] addr, input logic [31:0] val);
		step_result_t r;
		logic [31:0]  ins, a, b, imm, ea, pc4, nxt;
		r = '0;
		case (act)
			ACT_LD_IMEM: core_imem[addr[IMEM_AW+1:2]] = val;
			ACT_LD_DMEM: core_dmem[addr[DMEM_AW+1:2]] = val;
			ACT_RUN: begin
				ins = core_imem[core_pc[IMEM_AW+1:2]];
				a   = core_gpr[ins[25:21]];
				b   = core_gpr[ins[20:16]];
				imm = {{16{ins[15]}}, ins[15:0]};
				ea  = a + imm;
				pc4 = core_pc + 32'd4;
				nxt = pc4;
				r.instr = ins;
				case (ins[31:26])
					OPC_LW: begin
						r.reg_wr  = 1'b1;
						r.reg_idx = ins[20:16];
						r.reg_val = core_dmem[ea[DMEM_AW+1:2]];
					end
					OPC_SW: begin
						r.mem_wr   = 1'b1;
						r.mem_addr = ea;
						r.mem_val  = b;
					end
					OPC_RTYPE: begin
						r.reg_wr  = 1'b1;
						r.reg_idx = ins[15:11];
						case (ins[5:0])
							FN_ADD:  r.reg_val = a + b;
							FN_SUB:  r.reg_val = a - b;
							FN_AND:  r.reg_val = a & b;
							FN_OR:   r.reg_val = a | b;
							FN_SLT:  r.reg_val = (a < b) ? 32'd1 : 32'd0;
							default: r.reg_val = '0;
						endcase
					end
					OPC_BEQ: begin
						if (a == b) begin
							nxt     = pc4 + (imm << 2);
							r.taken = 1'b1;
						end
					end
					OPC_J: begin
						nxt     = {pc4[31:28], ins[25:0], 2'b00};
						r.taken = 1'b1;
					end
					default: ;
				endcase
				// writes to r0 are dropped and not reported
				if (r.reg_idx == '0) begin
					r.reg_wr  = 1'b0;
					r.reg_val = '0;
				end
				if (r.reg_wr)
					core_gpr[r.reg_idx] = r.reg_val;
				if (r.mem_wr)
					core_dmem[ea[DMEM_AW+1:2]] = b;
				core_pc = nxt;
			end
			default: ;
		endcase
		r.new_pc = core_pc;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_pc  = '0;
			core_gpr = '0;
			retire_q.delete();
			pending  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (retire_q.size() == 0) begin
					report("result word with nothing pending, new_pc", got.new_pc, '0);
				end else begin
					want = retire_q.pop_front();
					words_checked++;
					if (got.new_pc !== want.new_pc)
						report("new_pc", got.new_pc, want.new_pc);
					if (got.instr !== want.instr)
						report("executed_instruction", got.instr, want.instr);
					if (got.reg_wr !== want.reg_wr)
						report("reg_written", got.reg_wr, want.reg_wr);
					if (got.reg_idx !== want.reg_idx)
						report("reg_index", got.reg_idx, want.reg_idx);
					if (got.reg_val !== want.reg_val)
						report("reg_value", got.reg_val, want.reg_val);
					if (got.mem_wr !== want.mem_wr)
						report("mem_written", got.mem_wr, want.mem_wr);
					if (got.mem_addr !== want.mem_addr)
						report("mem_address", got.mem_addr, want.mem_addr);
					if (got.mem_val !== want.mem_val)
						report("mem_value", got.mem_val, want.mem_val);
					if (got.taken !== want.taken)
						report("flow_taken", got.taken, want.taken);
				end
			end
			if (s_tvalid && s_tready)
				retire_q.push_back(retire_item(s_tuser, s_tdata[11:0], s_tdata[43:12]));
			pending = retire_q.size();
		end
	end

endmodule

// File: tb/single_cycle_mips_core_step_top_tb.sv
// ----------------------------------------------------------------------------
// single_cycle_mips_core_step_top_tb
// Drives load and run words into the core step block: a short directed program
// over the corner cases, then random instructions placed at the PC just before
// they run, with lw addresses backed by written data. Both sides idle at random.
// ----------------------------------------------------------------------------
module single_cycle_mips_core_step_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [S_TDATA_W-1:0]        s_tdata;
	logic [1:0]                  s_tuser;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [M_TDATA_W-1:0]        m_tdata;

	int                          errors, pending, words_checked;
	logic [31:0]                 pc_state;
	logic [REG_COUNT-1:0][31:0]  gpr_state;

	logic [31:0]                 imem_shadow [IMEM_WORDS];
	bit                          imem_ok [IMEM_WORDS];
	bit                          dmem_ok [DMEM_WORDS];
	int                          n_run, n_load, n_ignored;
	bit                          tx_calm, rx_calm;

	single_cycle_mips_core_step_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	scm_step_monitor u_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.errors        (errors),
		.pending       (pending),
		.words_checked (words_checked),
		.pc_state      (pc_state),
		.gpr_state     (gpr_state)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(10ms);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
	endfunction

	function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
		input logic [4:0] rd, input logic [5:0] fn);
		return {OPC_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
		input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] make_instr();
		logic [4:0]  rs, rt, rd;
		logic [15:0] imm;
		logic [5:0]  op, fn;
		int          pick;
		rs   = pick_reg();
		rt   = pick_reg();
		rd   = pick_reg();
		imm  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 63)) - 16'd32;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			if ($urandom_range(0, 9) != 0) begin
				case ($urandom_range(0, 4))
					0:       fn = FN_ADD;
					1:       fn = FN_SUB;
					2:       fn = FN_AND;
					3:       fn = FN_OR;
					default: fn = FN_SLT;
				endcase
			end else begin
				do fn = 6'($urandom);
				while (fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR ||
					fn == FN_SLT);
			end
			return {OPC_RTYPE, rs, rt, rd, 5'($urandom), fn};
		end
		if (pick < 50)
			return itype(OPC_LW, rs, rt, imm);
		if (pick < 62)
			return itype(OPC_SW, rs, rt, imm);
		if (pick < 80)
			return itype(OPC_BEQ, rs, $urandom_range(0, 1) ? rs : rt, imm);
		if (pick < 86)
			return {OPC_J, $urandom_range(0, 1) ? 26'($urandom) : 26'($urandom_range(0, 255))};
		do op = 6'($urandom);
		while (op == OPC_RTYPE || op == OPC_J || op == OPC_BEQ || op == OPC_LW || op == OPC_SW);
		return {op, 26'($urandom)};
	endfunction

	// Offers one word and returns at the falling edge after it was taken.
	task automatic send_word(input logic [1:0] act, input logic [11:0] addr,
		input logic [31:0] val);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, val, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		case (act)
			ACT_RUN: n_run++;
			ACT_LD_IMEM: begin
				imem_shadow[addr[IMEM_AW+1:2]] = val;
				imem_ok[addr[IMEM_AW+1:2]]     = 1'b1;
				n_load++;
			end
			ACT_LD_DMEM: begin
				dmem_ok[addr[DMEM_AW+1:2]] = 1'b1;
				n_load++;
			end
			default: n_ignored++;
		endcase
	endtask

	// One core step: makes sure the word at PC and any lw target hold written data.
	task automatic step_core(input logic [31:0] ins, input bit reload);
		logic [IMEM_AW-1:0] w;
		logic [31:0]        cur, ea;
		w = pc_state[IMEM_AW+1:2];
		if (reload || !imem_ok[w])
			send_word(ACT_LD_IMEM, {w, 2'($urandom)}, ins);
		cur = imem_shadow[w];
		ea  = gpr_state[cur[25:21]] + {{16{cur[15]}}, cur[15:0]};
		if (cur[31:26] == OPC_LW && !dmem_ok[ea[DMEM_AW+1:2]])
			send_word(ACT_LD_DMEM, {ea[DMEM_AW+1:2], 2'($urandom)}, rand_word());
		if (cur[31:26] == OPC_SW)
			dmem_ok[ea[DMEM_AW+1:2]] = 1'b1;
		send_word(ACT_RUN, 12'($urandom), $urandom);
	endtask

	initial begin
		int stall;
		int taken_words;
		m_tready    = 1'b0;
		rx_calm     = 1'b0;
		taken_words = 0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 5);
			// long back-pressure so the pipeline fills and stalls the input
			if (taken_words == 30 || taken_words == 700)
				stall = 150;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			taken_words++;
			@(negedge clk);
		end
	end

	initial begin
		int roll;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_RUN;
		tx_calm   = 1'b0;
		n_run     = 0;
		n_load    = 0;
		n_ignored = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed program over the corner cases
		send_word(ACT_LD_DMEM, 12'hFFF, 32'hFFFF_FFFF);
		send_word(ACT_LD_DMEM, 12'h000, 32'h8000_0000);
		send_word(ACT_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
		step_core(itype(OPC_LW, 5'd0, 5'd1, 16'h0000), 1'b1);
		step_core(itype(OPC_LW, 5'd0, 5'd2, 16'hFFFC), 1'b1);   // wraps to last word
		step_core(rtype(5'd1, 5'd1, 5'd3, FN_ADD), 1'b1);       // overflow to zero
		step_core(rtype(5'd0, 5'd2, 5'd4, FN_SUB), 1'b1);
		step_core(rtype(5'd4, 5'd2, 5'd5, FN_SLT), 1'b1);       // unsigned compare
		step_core(rtype(5'd2, 5'd1, 5'd0, FN_OR), 1'b1);        // r0 write dropped
		step_core(rtype(5'd2, 5'd2, 5'd8, 6'h3F), 1'b1);        // unknown funct
		step_core(itype(OPC_SW, 5'd1, 5'd2, 16'h7FFC), 1'b1);
		step_core(itype(OPC_BEQ, 5'd3, 5'd0, 16'h0002), 1'b1);
		step_core(itype(OPC_BEQ, 5'd1, 5'd2, 16'h8000), 1'b1);
		step_core({OPC_J, 26'h3FF_FFFF}, 1'b1);
		step_core(32'hFFFF_FFFF, 1'b1);                         // unknown opcode

		while (n_run + n_load < 1775) begin
			if ($urandom_range(0, 63) == 0)
				tx_calm = !tx_calm;
			roll = $urandom_range(0, 99);
			if (roll < 6)
				send_word(ACT_UNUSED, 12'($urandom), rand_word());
			else if (roll < 16)
				send_word($urandom_range(0, 1) ? ACT_LD_IMEM : ACT_LD_DMEM, 12'($urandom),
					rand_word());
			else
				step_core(make_instr(), $urandom_range(0, 3) != 0);
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Covered %0d core cycles, %0d memory loads, %0d ignored words",
			n_run, n_load, n_ignored);
		$display("Compared %0d result words, %0d field mismatches", words_checked, errors);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/scm_pkg.sv
rtl/scm_regfile.sv
rtl/scm_exec.sv
rtl/single_cycle_mips_core_step_top.sv
tb/scm_step_monitor.sv
tb/single_cycle_mips_core_step_top_tb.sv
